// ----- design/imq_pkg.sv -----
// shared constants and types for the indexed min priority queue
`default_nettype none
package imq_pkg;
    localparam int CAPACITY_DEF  = 64;
    localparam int KEY_WIDTH_DEF = 32;
    localparam int CMD_W         = 3;
    localparam int STATUS_W      = 3;
    localparam int IDX_IN_W      = 6;
    localparam int KEY_IN_W      = 32;
    localparam int COUNT_OUT_W   = 7;

    typedef enum logic [CMD_W-1:0] {
        CMD_INSERT   = 3'd0,
        CMD_DEL_MIN  = 3'd1,
        CMD_CHANGE   = 3'd2,
        CMD_DECREASE = 3'd3,
        CMD_QUERY    = 3'd4
    } cmd_t;

    localparam logic [STATUS_W-1:0] ST_OK          = 3'd0;
    localparam logic [STATUS_W-1:0] ST_PRESENT     = 3'd1;
    localparam logic [STATUS_W-1:0] ST_ABSENT      = 3'd2;
    localparam logic [STATUS_W-1:0] ST_EMPTY       = 3'd3;
    localparam logic [STATUS_W-1:0] ST_NOT_SMALLER = 3'd4;
endpackage
`default_nettype wire

// ----- design/imq_ram.sv -----
// generic two-port ram with registered read
`default_nettype none
module imq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

// ----- design/indexed_min_priority_queue_core.sv -----
// top level of the indexed min priority queue
//
// one command beat on s_axis returns one result beat on m_axis.
// s_axis_tdata holds command, slot_index, new_key from the low bits up.
// m_axis_tdata holds status, min_index, min_key, slot_present, slot_key,
// item_count from the low bits up.
// heap order, keys and positions live in three rams with a registered read,
// so a command runs through a sequencer: lookup, then swim level by level
// (S_UP, S_UPW, S_UPC, S_UPS) and sink level by level (S_DN to S_DNS), then
// S_FIN, S_FINW and S_FINK to read back the result. the next command is
// taken in the cycle after the result beat has left.
// after reset a clearing pass writes every position entry to absent
// while s_axis_tready stays low.
// the result is held in an output register; while the receiver stalls the
// block waits with s_axis_tready low.
`default_nettype none
module indexed_min_priority_queue_core
    import imq_pkg::*;
#(
    parameter int CAPACITY  = imq_pkg::CAPACITY_DEF,
    parameter int KEY_WIDTH = imq_pkg::KEY_WIDTH_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [47:0] s_axis_tdata,  // command, slot_index, new_key, zero pad
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [87:0]      m_axis_tdata   // status, min_index, min_key, slot_present, slot_key, item_count, zero pad
);
    localparam int AW = $clog2(CAPACITY);
    localparam int PW = $clog2(CAPACITY + 1);
    localparam logic [PW-1:0] CAP_P = PW'(CAPACITY);

    typedef enum logic [18:0] {
        S_CLEAR = 19'h00001, S_IDLE  = 19'h00002, S_LOOK  = 19'h00004,
        S_DEL1  = 19'h00008, S_DEL2  = 19'h00010, S_DEL3  = 19'h00020,
        S_UP    = 19'h00040, S_UPW   = 19'h00080, S_UPC   = 19'h00100,
        S_UPS   = 19'h00200, S_DN    = 19'h00400, S_DNW1  = 19'h00800,
        S_DNR   = 19'h01000, S_DNR2  = 19'h02000, S_DNC   = 19'h04000,
        S_DNS   = 19'h08000, S_FIN   = 19'h10000, S_FINW  = 19'h20000,
        S_FINK  = 19'h40000
    } state_t;

    state_t state_reg, state_next;

    // ram ports
    logic           h_we;  logic [AW-1:0] h_wa, h_ra; logic [AW-1:0] h_wd, h_rd;
    logic           p_we;  logic [AW-1:0] p_wa, p_ra; logic [PW-1:0] p_wd, p_rd;
    logic           k_we;  logic [AW-1:0] k_wa, k_ra; logic [KEY_WIDTH-1:0] k_wd, k_rd;

    imq_ram #(.WIDTH(AW), .DEPTH(CAPACITY)) u_heap (
        .clk(clk), .we(h_we), .waddr(h_wa), .wdata(h_wd), .raddr(h_ra), .rdata(h_rd));
    imq_ram #(.WIDTH(PW), .DEPTH(CAPACITY)) u_pos (
        .clk(clk), .we(p_we), .waddr(p_wa), .wdata(p_wd), .raddr(p_ra), .rdata(p_rd));
    imq_ram #(.WIDTH(KEY_WIDTH), .DEPTH(CAPACITY)) u_key (
        .clk(clk), .we(k_we), .waddr(k_wa), .wdata(k_wd), .raddr(k_ra), .rdata(k_rd));

    logic [CMD_W-1:0]     cmd_reg;
    logic [IDX_IN_W-1:0]  idx_reg;
    logic [KEY_WIDTH-1:0] nkey_reg;
    logic                 valid_reg;
    logic [PW-1:0]        count_reg, count_next;
    logic [AW-1:0]        clr_reg, clr_next;
    logic [PW-1:0]        cur_reg, cur_next;      // position being moved
    logic [AW-1:0]        cslot_reg, cslot_next;  // slot at cur
    logic [KEY_WIDTH-1:0] ckey_reg, ckey_next;
    logic [PW-1:0]        oth_reg, oth_next;      // parent or chosen child
    logic [AW-1:0]        oslot_reg, oslot_next;
    logic [KEY_WIDTH-1:0] okey_reg, okey_next;
    logic [AW-1:0]        tslot_reg, tslot_next;  // right child slot
    logic                 sinkp_reg, sinkp_next;  // change key: sink after swim
    logic [STATUS_W-1:0]  st_reg, st_next;
    logic                 rem_reg, rem_next;
    logic [AW-1:0]        remi_reg, remi_next;
    logic [KEY_WIDTH-1:0] remk_reg, remk_next;
    logic [AW-1:0]        mini_reg, mini_next;
    logic                 pres_reg, pres_next;
    logic [KEY_WIDTH-1:0] skey_reg, skey_next;
    logic                 mv_reg, mv_next;

    logic [AW-1:0]        sidx;
    logic [AW-1:0]        in_idx;
    logic [KEY_WIDTH-1:0] in_key;
    logic [PW:0]          child;
    logic                 show_min;
    logic [AW-1:0]        min_slot;
    logic [KEY_WIDTH-1:0] min_key_w;
    logic [87:0]          out_data;

    assign sidx   = AW'(idx_reg);
    assign in_idx = AW'(s_axis_tdata[CMD_W +: IDX_IN_W]);
    assign in_key = KEY_WIDTH'($signed(s_axis_tdata[CMD_W + IDX_IN_W +: KEY_IN_W]));
    assign s_axis_tready = (state_reg == S_IDLE) && !mv_reg;
    assign m_axis_tvalid = mv_reg;

    function automatic logic [AW-1:0] pa(input logic [PW-1:0] p);
        pa = AW'(p - PW'(1));
    endfunction

    always_comb
    begin
        state_next = state_reg;  count_next = count_reg;  clr_next = clr_reg;
        cur_next = cur_reg;  cslot_next = cslot_reg;  ckey_next = ckey_reg;
        oth_next = oth_reg;  oslot_next = oslot_reg;  okey_next = okey_reg;
        tslot_next = tslot_reg;  sinkp_next = sinkp_reg;  st_next = st_reg;
        rem_next = rem_reg;  remi_next = remi_reg;  remk_next = remk_reg;
        mini_next = mini_reg;  pres_next = pres_reg;  skey_next = skey_reg;
        mv_next = mv_reg;
        h_we = 1'b0; h_wa = '0; h_wd = '0; h_ra = '0;
        p_we = 1'b0; p_wa = '0; p_wd = '0; p_ra = '0;
        k_we = 1'b0; k_wa = '0; k_wd = '0; k_ra = '0;
        child = {cur_reg, 1'b0};
        if (mv_reg && m_axis_tready)
        begin
            mv_next = 1'b0;
        end
        unique case (state_reg)
            S_CLEAR:
            begin
                p_we = 1'b1; p_wa = clr_reg; p_wd = '0;
                clr_next = clr_reg + 1'b1;
                if (clr_reg == AW'(CAPACITY - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                // lookup reads for the incoming beat
                p_ra = in_idx; k_ra = in_idx; h_ra = '0;
                if (s_axis_tvalid && s_axis_tready)
                begin
                    state_next = S_LOOK;
                end
            end
            S_LOOK:
            begin
                // p_rd position of slot, k_rd key of slot, h_rd heap top
                st_next = ST_OK; rem_next = 1'b0; sinkp_next = 1'b0;
                state_next = S_FIN;
                unique case (cmd_reg)
                    CMD_INSERT:
                    begin
                        if (!valid_reg)
                        begin
                            st_next = ST_ABSENT;
                        end
                        else if (p_rd != '0 || count_reg >= CAP_P)
                        begin
                            st_next = ST_PRESENT;
                        end
                        else
                        begin
                            count_next = count_reg + PW'(1);
                            p_we = 1'b1; p_wa = sidx; p_wd = count_reg + PW'(1);
                            h_we = 1'b1; h_wa = AW'(count_reg); h_wd = sidx;
                            k_we = 1'b1; k_wa = sidx; k_wd = nkey_reg;
                            cur_next = count_reg + PW'(1); cslot_next = sidx;
                            ckey_next = nkey_reg; state_next = S_UP;
                        end
                    end
                    CMD_DEL_MIN:
                    begin
                        if (count_reg == '0)
                        begin
                            st_next = ST_EMPTY;
                        end
                        else
                        begin
                            rem_next = 1'b1; remi_next = h_rd;
                            state_next = S_DEL1;
                        end
                    end
                    CMD_CHANGE, CMD_DECREASE:
                    begin
                        if (!valid_reg || p_rd == '0)
                        begin
                            st_next = ST_ABSENT;
                        end
                        else if (cmd_reg == CMD_DECREASE &&
                                 !($signed(k_rd) > $signed(nkey_reg)))
                        begin
                            st_next = ST_NOT_SMALLER;
                        end
                        else
                        begin
                            k_we = 1'b1; k_wa = sidx; k_wd = nkey_reg;
                            cur_next = p_rd; cslot_next = sidx; ckey_next = nkey_reg;
                            sinkp_next = (cmd_reg == CMD_CHANGE);
                            state_next = S_UP;
                        end
                    end
                    default: ;
                endcase
            end
            S_DEL1:
            begin
                // fetch last heap slot and key of removed slot
                h_ra = AW'(count_reg - PW'(1));
                k_ra = remi_reg;
                state_next = S_DEL2;
            end
            S_DEL2:
            begin
                // move last slot to the top
                remk_next = k_rd;
                h_we = 1'b1; h_wa = '0; h_wd = h_rd;
                p_we = 1'b1; p_wa = h_rd; p_wd = PW'(1);
                cslot_next = h_rd; cur_next = PW'(1);
                count_next = count_reg - PW'(1);
                k_ra = h_rd;
                state_next = S_DEL3;
            end
            S_DEL3:
            begin
                ckey_next = k_rd;
                state_next = S_DN;
            end
            S_UP:
            begin
                if (cur_reg <= PW'(1))
                begin
                    state_next = sinkp_reg ? S_DN : S_FIN;
                end
                else
                begin
                    oth_next = cur_reg >> 1;
                    h_ra = pa(cur_reg >> 1);
                    state_next = S_UPW;
                end
            end
            S_UPW:
            begin
                oslot_next = h_rd; k_ra = h_rd; state_next = S_UPC;
            end
            S_UPC:
            begin
                if ($signed(k_rd) > $signed(ckey_reg))
                begin
                    h_we = 1'b1; h_wa = pa(oth_reg); h_wd = cslot_reg;
                    p_we = 1'b1; p_wa = cslot_reg; p_wd = oth_reg;
                    state_next = S_UPS;
                end
                else
                begin
                    state_next = sinkp_reg ? S_DN : S_FIN;
                end
            end
            S_UPS:
            begin
                h_we = 1'b1; h_wa = pa(cur_reg); h_wd = oslot_reg;
                p_we = 1'b1; p_wa = oslot_reg; p_wd = cur_reg;
                cur_next = oth_reg;
                state_next = S_UP;
            end
            S_DN:
            begin
                if (child > {1'b0, count_reg})
                begin
                    state_next = S_FIN;
                end
                else
                begin
                    oth_next = child[PW-1:0];
                    h_ra = pa(child[PW-1:0]);
                    state_next = S_DNW1;
                end
            end
            S_DNW1:
            begin
                oslot_next = h_rd; k_ra = h_rd;
                if (oth_reg < count_reg)
                begin
                    h_ra = pa(oth_reg + PW'(1));
                end
                state_next = S_DNR;
            end
            S_DNR:
            begin
                okey_next = k_rd;
                if (oth_reg < count_reg)
                begin
                    tslot_next = h_rd; k_ra = h_rd;
                    state_next = S_DNR2;
                end
                else
                begin
                    state_next = S_DNC;
                end
            end
            S_DNR2:
            begin
                if ($signed(okey_reg) > $signed(k_rd))
                begin
                    okey_next = k_rd; oslot_next = tslot_reg;
                    oth_next = oth_reg + PW'(1);
                end
                state_next = S_DNC;
            end
            S_DNC:
            begin
                if ($signed(ckey_reg) > $signed(okey_reg))
                begin
                    h_we = 1'b1; h_wa = pa(oth_reg); h_wd = cslot_reg;
                    p_we = 1'b1; p_wa = cslot_reg; p_wd = oth_reg;
                    state_next = S_DNS;
                end
                else
                begin
                    state_next = S_FIN;
                end
            end
            S_DNS:
            begin
                h_we = 1'b1; h_wa = pa(cur_reg); h_wd = oslot_reg;
                p_we = 1'b1; p_wa = oslot_reg; p_wd = cur_reg;
                cur_next = oth_reg;
                state_next = S_DN;
            end
            S_FIN:
            begin
                if (rem_reg)
                begin
                    p_we = 1'b1; p_wa = remi_reg; p_wd = '0;
                end
                h_ra = '0; p_ra = sidx; k_ra = sidx;
                state_next = S_FINW;
            end
            S_FINW:
            begin
                // h_rd top slot, p_rd slot position, k_rd slot key
                pres_next = valid_reg && p_rd != '0 && !(rem_reg && sidx == remi_reg);
                skey_next = pres_next ? k_rd : '0;
                mini_next = h_rd; k_ra = h_rd;
                state_next = S_FINK;
            end
            S_FINK:
            begin
                mv_next = 1'b1;
                state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    // k_rd holds the top key while in S_FINK
    assign show_min  = rem_reg || count_reg != '0;
    assign min_slot  = rem_reg ? remi_reg : mini_reg;
    assign min_key_w = rem_reg ? remk_reg : k_rd;
    assign out_data  = {7'd0,
                        COUNT_OUT_W'(count_reg),
                        32'($signed(skey_reg)),
                        pres_reg,
                        show_min ? 32'($signed(min_key_w)) : 32'd0,
                        show_min ? IDX_IN_W'(min_slot) : {IDX_IN_W{1'b0}},
                        st_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            count_reg <= '0;
            clr_reg   <= '0;
            mv_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            clr_reg   <= clr_next;
            mv_reg    <= mv_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            cmd_reg   <= s_axis_tdata[CMD_W-1:0];
            idx_reg   <= s_axis_tdata[CMD_W +: IDX_IN_W];
            nkey_reg  <= in_key;
            valid_reg <= 32'(s_axis_tdata[CMD_W +: IDX_IN_W]) < 32'(CAPACITY);
        end
        cur_reg <= cur_next; cslot_reg <= cslot_next; ckey_reg <= ckey_next;
        oth_reg <= oth_next; oslot_reg <= oslot_next; okey_reg <= okey_next;
        tslot_reg <= tslot_next; sinkp_reg <= sinkp_next; st_reg <= st_next;
        rem_reg <= rem_next; remi_reg <= remi_next; remk_reg <= remk_next;
        mini_reg <= mini_next; pres_reg <= pres_next; skey_reg <= skey_next;
        if (state_reg == S_FINK)
        begin
            m_axis_tdata <= out_data;
        end
    end
endmodule
`default_nettype wire

// ----- design/imq_checker.sv -----
// port-level checker for the indexed min priority queue
`default_nettype none
module imq_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        s_axis_tvalid,
    input wire logic        s_axis_tready,
    input wire logic        m_axis_tvalid,
    input wire logic        m_axis_tready,
    input wire logic [87:0] m_axis_tdata
);
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result dropped");
    a_excl: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> !s_axis_tready)
        else $error("accept while result pending");
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("second accept during command");
    a_cnt: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tdata[80:74] <= 7'd64)
        else $error("count overflow");
endmodule

bind indexed_min_priority_queue_core imq_checker u_imq_checker (
    .clk(clk), .rst_n(rst_n), .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready), .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready), .m_axis_tdata(m_axis_tdata));
`default_nettype wire

// ----- dv/tb_top.sv -----
// testbench for the indexed min priority queue: directed and random commands against a heap model
`timescale 1ns / 100ps
`default_nettype none
module tb_top;
    import imq_pkg::*;

    localparam int SLOTS = 64;
    localparam int IDLE_LIMIT = 20000;

    // lowest field last
    typedef struct packed {
        logic [6:0]  item_count;
        logic [31:0] slot_key;
        logic        slot_present;
        logic [31:0] min_key;
        logic [5:0]  min_index;
        logic [2:0]  status;
    } reply_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    wire         s_axis_tready;
    logic [47:0] s_axis_tdata = '0;
    wire         m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    wire  [87:0] m_axis_tdata;

    indexed_min_priority_queue_core uut (
        .clk(clk), .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata)
    );

    always #1 clk = ~clk;

    // heap model
    logic [5:0]  heap_at [SLOTS];
    int          pos_of  [SLOTS];
    logic signed [31:0] key_of [SLOTS];
    int          queued;
    reply_t      expected_replies[$];
    int          errors = 0;
    int          idle_cycles = 0;
    bit          hold_off = 1'b0;
    bit          stall_rare = 1'b0;

    function automatic logic signed [31:0] key_at(int p);
        return key_of[heap_at[p-1]];
    endfunction

    function automatic void swap_pos(int a, int b);
        logic [5:0] t;
        t = heap_at[a-1];
        heap_at[a-1] = heap_at[b-1];
        heap_at[b-1] = t;
        pos_of[heap_at[a-1]] = a;
        pos_of[heap_at[b-1]] = b;
    endfunction

    function automatic void swim(int p);
        while (p > 1 && key_at(p/2) > key_at(p))
        begin
            swap_pos(p, p/2);
            p = p/2;
        end
    endfunction

    function automatic void sink(int p);
        int c;
        while (2*p <= queued)
        begin
            c = 2*p;
            if (c < queued && key_at(c) > key_at(c+1))
                c++;
            if (!(key_at(p) > key_at(c)))
                break;
            swap_pos(p, c);
            p = c;
        end
    endfunction

    function automatic reply_t heap_apply(logic [2:0] cmd, logic [5:0] idx,
                                          logic signed [31:0] key);
        reply_t r;
        bit removed;
        r = '0;
        removed = 0;
        case (cmd)
            CMD_INSERT:
                if (pos_of[idx] != 0 || queued >= SLOTS)
                    r.status = ST_PRESENT;
                else
                begin
                    queued++;
                    pos_of[idx] = queued;
                    heap_at[queued-1] = idx;
                    key_of[idx] = key;
                    swim(queued);
                end
            CMD_DEL_MIN:
                if (queued == 0)
                    r.status = ST_EMPTY;
                else
                begin
                    r.min_index = heap_at[0];
                    r.min_key = key_of[heap_at[0]];
                    removed = 1;
                    swap_pos(1, queued);
                    queued--;
                    sink(1);
                    pos_of[r.min_index] = 0;
                end
            CMD_CHANGE:
                if (pos_of[idx] == 0)
                    r.status = ST_ABSENT;
                else
                begin
                    key_of[idx] = key;
                    swim(pos_of[idx]);
                    sink(pos_of[idx]);
                end
            CMD_DECREASE:
                if (pos_of[idx] == 0)
                    r.status = ST_ABSENT;
                else if (!(key_of[idx] > key))
                    r.status = ST_NOT_SMALLER;
                else
                begin
                    key_of[idx] = key;
                    swim(pos_of[idx]);
                end
            default: ;
        endcase
        if (!removed && queued > 0)
        begin
            r.min_index = heap_at[0];
            r.min_key = key_of[heap_at[0]];
        end
        r.slot_present = pos_of[idx] != 0;
        r.slot_key = r.slot_present ? key_of[idx] : '0;
        r.item_count = queued[6:0];
        return r;
    endfunction

    task automatic send_command(logic [2:0] cmd, logic [5:0] idx, logic [31:0] key);
        int gap;
        gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 60) : $urandom_range(0, 2);
        if ($urandom_range(0, 3) == 0)
            gap = 0;
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_axis_tdata <= {7'd0, key, idx, cmd};
        s_axis_tvalid <= 1'b1;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        expected_replies.push_back(heap_apply(cmd, idx, key));
        @(negedge clk);
    endtask

    always @(negedge clk)
    begin
        if (hold_off)
            m_axis_tready <= 1'b0;
        else if (stall_rare)
            m_axis_tready <= ($urandom_range(0, 19) != 0);
        else if ($urandom_range(0, 29) == 0)
            m_axis_tready <= 1'b0;
        else
            m_axis_tready <= ($urandom_range(0, 3) != 0);
    end

    always @(posedge clk)
    begin
        reply_t got;
        reply_t want;
        if (m_axis_tvalid && m_axis_tready)
        begin
            got = m_axis_tdata[80:0];
            if (expected_replies.size() == 0)
            begin
                $display("%0t: unexpected reply %h", $time, got);
                errors++;
            end
            else
            begin
                want = expected_replies.pop_front();
                if (got !== want)
                begin
                    $display("%0t: status exp %0d got %0d", $time, want.status, got.status);
                    $display("%0t: min exp %0d/%0d got %0d/%0d", $time, want.min_index,
                             $signed(want.min_key), got.min_index, $signed(got.min_key));
                    $display("%0t: slot exp %0b/%0d got %0b/%0d", $time, want.slot_present,
                             $signed(want.slot_key), got.slot_present, $signed(got.slot_key));
                    $display("%0t: count exp %0d got %0d", $time, want.item_count,
                             got.item_count);
                    errors++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > IDLE_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    function automatic logic [31:0] rand_key();
        case ($urandom_range(0, 5))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return 32'($urandom_range(0, 15)) - 32'd8;
            default: return $urandom;
        endcase
    endfunction

    task automatic test_directed();
        send_command(CMD_DEL_MIN, 6'd0, '0);
        send_command(CMD_QUERY, 6'd63, '0);
        send_command(CMD_CHANGE, 6'd5, 32'd1);
        send_command(CMD_DECREASE, 6'd5, 32'd1);
        send_command(CMD_INSERT, 6'd63, 32'h7fff_ffff);
        send_command(CMD_INSERT, 6'd0, 32'h8000_0000);
        send_command(CMD_INSERT, 6'd0, 32'd3);
        send_command(CMD_INSERT, 6'd21, 32'd0);
        send_command(CMD_INSERT, 6'd42, 32'd0);
        send_command(CMD_DECREASE, 6'd42, 32'd0);
        send_command(CMD_DECREASE, 6'd63, 32'hffff_ffff);
        send_command(CMD_CHANGE, 6'd0, 32'h7fff_ffff);
        send_command(CMD_CHANGE, 6'd21, 32'h8000_0000);
        send_command(3'd5, 6'd21, 32'hdead_beef);
        send_command(3'd7, 6'd2, '0);
        send_command(3'd6, 6'd42, '0);
        repeat (5) send_command(CMD_DEL_MIN, 6'd0, 32'hffff_ffff);
    endtask

    task automatic test_fill_and_stall();
        int cycles;
        hold_off = 1'b1;
        fork
            begin
                cycles = 0;
                while (cycles < 400)
                begin
                    @(posedge clk);
                    cycles++;
                end
                hold_off = 1'b0;
            end
            for (int i = 0; i < SLOTS; i++)
                send_command(CMD_INSERT, i[5:0], rand_key());
        join
        repeat (20) send_command(CMD_INSERT, 6'($urandom_range(0, 63)), rand_key());
        for (int i = 0; i < SLOTS + 2; i++)
            send_command(CMD_DEL_MIN, 6'($urandom_range(0, 63)), rand_key());
    endtask

    task automatic test_random(int n);
        logic [2:0] cmd;
        logic [5:0] idx;
        logic [31:0] key;
        int w;
        for (int i = 0; i < n; i++)
        begin
            stall_rare = ((i / 200) % 2) != 0;
            idx = (queued > 40) ? 6'($urandom_range(0, 63)) : 6'($urandom_range(0, 47));
            w = $urandom_range(0, 99);
            if (w < 35) cmd = CMD_INSERT;
            else if (w < 55) cmd = CMD_DEL_MIN;
            else if (w < 70) cmd = CMD_CHANGE;
            else if (w < 88) cmd = CMD_DECREASE;
            else if (w < 96) cmd = CMD_QUERY;
            else cmd = 3'($urandom_range(5, 7));
            key = rand_key();
            if (cmd == CMD_DECREASE && pos_of[idx] != 0 && $urandom_range(0, 3) != 0
                && key_of[idx] != 32'sh8000_0000)
                key = 32'(key_of[idx]) - 32'($urandom_range(1, 100));
            send_command(cmd, idx, key);
        end
    endtask

    initial
    begin
        queued = 0;
        foreach (pos_of[i])
        begin
            pos_of[i] = 0;
            key_of[i] = '0;
            heap_at[i] = '0;
        end
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        test_directed();
        test_fill_and_stall();
        test_random(1600);
        s_axis_tvalid <= 1'b0;
        while (expected_replies.size() != 0)
            @(posedge clk);
        repeat (100) @(posedge clk);
        if (errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end
endmodule
`default_nettype wire

// ----- filelist.f -----
design/imq_pkg.sv
design/imq_ram.sv
design/indexed_min_priority_queue_core.sv
design/imq_checker.sv
dv/tb_top.sv
